FILE: sv/cbqv_pkg.sv
// shared constants, types and command/status structs for the quantized value count block
package cbqv_pkg;

    localparam int ENTRY_BITS = 24;
    localparam int DIM_BITS   = 16;
    localparam int OUT_BITS   = 40;
    localparam int MAP_BITS   = 2;

    // multiplier operand width covers both entry count and dimension
    localparam int MUL_W  = (ENTRY_BITS > DIM_BITS) ? ENTRY_BITS : DIM_BITS;
    localparam int PROD_W = 2 * MUL_W;
    localparam int BIT_W  = $clog2(ENTRY_BITS);

    // lookup map kinds
    localparam logic [MAP_BITS-1:0] MAP_NONE    = 2'd0;
    localparam logic [MAP_BITS-1:0] MAP_LATTICE = 2'd1;
    localparam logic [MAP_BITS-1:0] MAP_LIST    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BIT,
        S_MUL,
        S_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;         // capture the input item, clear the search
        logic start_mul;    // reset power accumulator and step counter
        logic mul_step;     // one multiply of the running power
        logic take_cand;    // candidate fits, keep its bit
        logic dec_bit;      // move to the next lower candidate bit
        logic mul_lattice;  // multiplier works on power and candidate
        logic write_out;    // load the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic lattice;      // item uses the lattice map
        logic trivial;      // no entries or zero dimension
        logic cand_one;     // current candidate equals one
        logic over;         // running power exceeds entry count
        logic last_iter;    // this multiply reaches the full dimension
        logic bit_zero;     // lowest candidate bit in work
    } sts_t;

endpackage

FILE: sv/codebook_quant_value_count.sv
// top level: codebook quantized value count, controller plus datapath
//
// Input channel (in_valid/in_ready) carries entry_count, dimension and
// map_kind; output channel (out_valid/out_ready) carries value_count.
// One result item per input item, in order.
// Map kind none (and the unused code) gives 0, the explicit list gives
// entry_count times dimension, the lattice gives the largest v with
// v to the power dimension not above entry_count.
// Timing: the list and none kinds pass from acceptance through the bit
// and finish states to out_valid. The lattice search walks ENTRY_BITS
// candidate bits from the top; each bit takes a step in the bit state
// plus the multiplies of the shared multiplier, and the multiply chain
// stops as soon as the power passes entry_count or reaches the full
// dimension.
// One item is in work at a time; in_ready is high only while idle.
// A finished result sits in the output register, so a new item can be
// taken while the receiver stalls; that item then waits for the output
// register before writing its result.
// Reset clears the controller and the output valid; no item is lost to
// a stall.
module codebook_quant_value_count
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cbqv_pkg::ENTRY_BITS-1:0]  entry_count,
    input  logic [cbqv_pkg::DIM_BITS-1:0]    dimension,
    input  logic [cbqv_pkg::MAP_BITS-1:0]    map_kind,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cbqv_pkg::OUT_BITS-1:0]    value_count
);

    cbqv_pkg::cmd_t cmd;
    cbqv_pkg::sts_t sts;

    // sequencing
    cbqv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and storage
    cbqv_dp u_dp
    (
        .clk         (clk),
        .entry_count (entry_count),
        .dimension   (dimension),
        .map_kind    (map_kind),
        .cmd         (cmd),
        .sts         (sts),
        .value_count (value_count)
    );

endmodule

FILE: sv/cbqv_ctrl.sv
// controller state machine for the bit-by-bit root search
module cbqv_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  cbqv_pkg::sts_t sts,
    output cbqv_pkg::cmd_t cmd
);

    cbqv_pkg::state_t state_reg;
    cbqv_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbqv_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            cbqv_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = cbqv_pkg::S_BIT;
                end
            end
            cbqv_pkg::S_BIT:
            begin
                if (!sts.lattice || sts.trivial)
                begin
                    state_next = cbqv_pkg::S_FINISH;
                end
                else if (sts.cand_one)
                begin
                    // one to any power is one, entry count is nonzero here
                    cmd.take_cand = 1'b1;
                    if (sts.bit_zero)
                    begin
                        state_next = cbqv_pkg::S_FINISH;
                    end
                    else
                    begin
                        cmd.dec_bit = 1'b1;
                    end
                end
                else
                begin
                    cmd.start_mul = 1'b1;
                    state_next    = cbqv_pkg::S_MUL;
                end
            end
            cbqv_pkg::S_MUL:
            begin
                cmd.mul_step    = 1'b1;
                cmd.mul_lattice = 1'b1;
                if (sts.over || sts.last_iter)
                begin
                    cmd.take_cand = !sts.over;
                    if (sts.bit_zero)
                    begin
                        state_next = cbqv_pkg::S_FINISH;
                    end
                    else
                    begin
                        cmd.dec_bit = 1'b1;
                        state_next  = cbqv_pkg::S_BIT;
                    end
                end
            end
            cbqv_pkg::S_FINISH:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cbqv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cbqv_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // output register is only loaded when empty or draining
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_out |-> (!out_valid_reg || out_ready))
        else $error("output overwritten while a result is held");

    // an accepted item always starts the search
    a_accept_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == cbqv_pkg::S_BIT))
        else $error("accepted item did not start work");

    // a candidate whose power overflowed is never kept
    a_no_take_over: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbqv_pkg::S_MUL && sts.over) |-> !cmd.take_cand)
        else $error("overflowing candidate kept");

    // the output goes valid exactly after a write
    a_valid_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.write_out))
        else $error("result shown without a write");

endmodule

FILE: sv/cbqv_dp.sv
// datapath: item registers, shared multiplier, search registers and output register
module cbqv_dp
(
    input  logic                              clk,
    input  logic [cbqv_pkg::ENTRY_BITS-1:0]   entry_count,
    input  logic [cbqv_pkg::DIM_BITS-1:0]     dimension,
    input  logic [cbqv_pkg::MAP_BITS-1:0]     map_kind,
    input  cbqv_pkg::cmd_t                    cmd,
    output cbqv_pkg::sts_t                    sts,
    output logic [cbqv_pkg::OUT_BITS-1:0]     value_count
);

    logic [cbqv_pkg::ENTRY_BITS-1:0] entries_reg;
    logic [cbqv_pkg::DIM_BITS-1:0]   dim_reg;
    logic [cbqv_pkg::MAP_BITS-1:0]   kind_reg;
    logic [cbqv_pkg::ENTRY_BITS-1:0] v_reg;
    logic [cbqv_pkg::ENTRY_BITS-1:0] v_next;
    logic [cbqv_pkg::BIT_W-1:0]      bit_reg;
    logic [cbqv_pkg::BIT_W-1:0]      bit_next;
    logic [cbqv_pkg::ENTRY_BITS-1:0] acc_reg;
    logic [cbqv_pkg::ENTRY_BITS-1:0] acc_next;
    logic [cbqv_pkg::DIM_BITS-1:0]   cnt_reg;
    logic [cbqv_pkg::DIM_BITS-1:0]   cnt_next;
    logic [cbqv_pkg::OUT_BITS-1:0]   value_reg;
    logic [cbqv_pkg::OUT_BITS-1:0]   value_next;

    logic [cbqv_pkg::ENTRY_BITS-1:0] cand;
    logic [cbqv_pkg::MUL_W-1:0]      mul_a;
    logic [cbqv_pkg::MUL_W-1:0]      mul_b;
    logic [cbqv_pkg::PROD_W-1:0]     prod;
    logic [cbqv_pkg::DIM_BITS:0]     cnt_inc;

    // candidate is the kept value with the current bit set
    assign cand = v_reg | (cbqv_pkg::ENTRY_BITS'(1) << bit_reg);

    // shared multiplier: running power times candidate, or entries times dimension
    always_comb
    begin
        if (cmd.mul_lattice)
        begin
            mul_a = cbqv_pkg::MUL_W'(acc_reg);
            mul_b = cbqv_pkg::MUL_W'(cand);
        end
        else
        begin
            mul_a = cbqv_pkg::MUL_W'(entries_reg);
            mul_b = cbqv_pkg::MUL_W'(dim_reg);
        end
    end

    assign prod    = cbqv_pkg::PROD_W'(mul_a) * cbqv_pkg::PROD_W'(mul_b);
    assign cnt_inc = {1'b0, cnt_reg} + (cbqv_pkg::DIM_BITS+1)'(1);

    // status to controller
    always_comb
    begin
        sts.lattice   = (kind_reg == cbqv_pkg::MAP_LATTICE);
        sts.trivial   = (entries_reg == '0) || (dim_reg == '0);
        sts.cand_one  = (cand == cbqv_pkg::ENTRY_BITS'(1));
        sts.over      = (prod > cbqv_pkg::PROD_W'(entries_reg));
        sts.last_iter = (cnt_inc == {1'b0, dim_reg});
        sts.bit_zero  = (bit_reg == '0);
    end

    // search register updates
    always_comb
    begin
        v_next     = v_reg;
        bit_next   = bit_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        value_next = value_reg;
        if (cmd.load)
        begin
            v_next   = '0;
            bit_next = cbqv_pkg::BIT_W'(cbqv_pkg::ENTRY_BITS - 1);
        end
        if (cmd.start_mul)
        begin
            acc_next = cbqv_pkg::ENTRY_BITS'(1);
            cnt_next = '0;
        end
        if (cmd.mul_step)
        begin
            acc_next = prod[cbqv_pkg::ENTRY_BITS-1:0];
            cnt_next = cnt_inc[cbqv_pkg::DIM_BITS-1:0];
        end
        if (cmd.take_cand)
        begin
            v_next = cand;
        end
        if (cmd.dec_bit)
        begin
            bit_next = bit_reg - cbqv_pkg::BIT_W'(1);
        end
        if (cmd.write_out)
        begin
            case (kind_reg)
                cbqv_pkg::MAP_LATTICE: value_next = cbqv_pkg::OUT_BITS'(v_reg);
                cbqv_pkg::MAP_LIST:    value_next = cbqv_pkg::OUT_BITS'(prod);
                default:               value_next = '0;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            entries_reg <= entry_count;
            dim_reg     <= dimension;
            kind_reg    <= map_kind;
        end
        v_reg     <= v_next;
        bit_reg   <= bit_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        value_reg <= value_next;
    end

    assign value_count = value_reg;

endmodule

FILE: tb/sv/testbench.sv
// testbench for the codebook quantized value count block with a scoreboard class
module testbench;

    // map kind code that the package leaves unnamed
    localparam logic [cbqv_pkg::MAP_BITS-1:0] MAP_UNUSED = 2'd3;

    // expected value counts in acceptance order, with their predictor
    class count_book;
        logic [cbqv_pkg::OUT_BITS-1:0] expected_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // largest root with root to the power dim not above entries
        function bit [cbqv_pkg::OUT_BITS-1:0] lattice_root(
            bit [cbqv_pkg::ENTRY_BITS-1:0] entries,
            bit [cbqv_pkg::DIM_BITS-1:0] dim);
            bit [63:0] root;
            bit [63:0] cand;
            bit [63:0] acc;
            bit fits;
            int unsigned step;
            if (entries == 0 || dim == 0)
                return '0;
            root = 0;
            for (int b = cbqv_pkg::ENTRY_BITS - 1; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                fits = 1'b1;
                acc = 1;
                // a candidate of one always fits a nonzero entry count
                if (cand != 1)
                begin
                    for (step = 0; step < dim && fits; step++)
                    begin
                        acc = acc * cand;
                        if (acc > entries)
                            fits = 1'b0;
                    end
                end
                if (fits)
                    root = cand;
            end
            return root[cbqv_pkg::OUT_BITS-1:0];
        endfunction

        function bit [cbqv_pkg::OUT_BITS-1:0] value_count_of(
            bit [cbqv_pkg::ENTRY_BITS-1:0] entries,
            bit [cbqv_pkg::DIM_BITS-1:0] dim,
            bit [cbqv_pkg::MAP_BITS-1:0] kind);
            case (kind)
                cbqv_pkg::MAP_LATTICE: return lattice_root(entries, dim);
                cbqv_pkg::MAP_LIST:
                    return cbqv_pkg::OUT_BITS'(entries) * cbqv_pkg::OUT_BITS'(dim);
                default:     return '0;
            endcase
        endfunction

        function void note(bit [cbqv_pkg::ENTRY_BITS-1:0] entries,
                           bit [cbqv_pkg::DIM_BITS-1:0] dim,
                           bit [cbqv_pkg::MAP_BITS-1:0] kind);
            expected_q.push_back(value_count_of(entries, dim, kind));
        endfunction

        function void check(logic [cbqv_pkg::OUT_BITS-1:0] got);
            logic [cbqv_pkg::OUT_BITS-1:0] want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: value_count %0d arrived with none expected", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: value_count expected %0d actual %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [cbqv_pkg::ENTRY_BITS-1:0] entry_count;
    logic [cbqv_pkg::DIM_BITS-1:0]   dimension;
    logic [cbqv_pkg::MAP_BITS-1:0]   map_kind;
    logic                            out_valid;
    logic                            out_ready;
    logic [cbqv_pkg::OUT_BITS-1:0]   value_count;

    int send_idle;
    int recv_idle;
    count_book book;

    codebook_quant_value_count DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .entry_count (entry_count),
        .dimension   (dimension),
        .map_kind    (map_kind),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value_count (value_count)
    );

    // clock, period 4
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check(value_count);
    end

    // present one item, hold it until accepted, then note its expectation
    task automatic offer_item(input logic [cbqv_pkg::ENTRY_BITS-1:0] entries,
                              input logic [cbqv_pkg::DIM_BITS-1:0] dim,
                              input logic [cbqv_pkg::MAP_BITS-1:0] kind);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        entry_count <= entries;
        dimension   <= dim;
        map_kind    <= kind;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.note(entries, dim, kind);
        @(negedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        int phase;
        int pick;
        int unsigned root;
        bit [cbqv_pkg::OUT_BITS-1:0] top;
        bit [63:0] pw;
        logic [cbqv_pkg::ENTRY_BITS-1:0] entries;
        logic [cbqv_pkg::DIM_BITS-1:0] dim;
        logic [cbqv_pkg::MAP_BITS-1:0] kind;

        book = new();
        send_idle   = 12;
        recv_idle   = 86;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        entry_count = '0;
        dimension   = '0;
        map_kind    = cbqv_pkg::MAP_NONE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 12;
                    recv_idle = 86;
                end
                1:
                begin
                    send_idle = 86;
                    recv_idle = 12;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase

            // directed corners: no lookup, unused kind, zero sizes, exact powers
            if (phase == 0)
            begin
                offer_item(24'hFFFFFF, 16'hFFFF, cbqv_pkg::MAP_NONE);
                offer_item(24'hFFFFFF, 16'hFFFF, MAP_UNUSED);
                offer_item(24'hFFFFFF, 16'hFFFF, cbqv_pkg::MAP_LIST);
                offer_item(24'd0, 16'd5, cbqv_pkg::MAP_LIST);
                offer_item(24'd7, 16'd0, cbqv_pkg::MAP_LIST);
                offer_item(24'hAAAAAA, 16'h5555, cbqv_pkg::MAP_LIST);
                offer_item(24'd0, 16'd3, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd100, 16'd0, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd0, 16'd0, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd1, 16'd1, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd1, 16'hFFFF, cbqv_pkg::MAP_LATTICE);
                offer_item(24'hFFFFFF, 16'd1, cbqv_pkg::MAP_LATTICE);
                offer_item(24'hFFFFFF, 16'd2, cbqv_pkg::MAP_LATTICE);
                offer_item(24'hFFFFFF, 16'd24, cbqv_pkg::MAP_LATTICE);
                offer_item(24'hFFFFFF, 16'hFFFF, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd8, 16'd3, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd7, 16'd3, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd16769025, 16'd2, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd16769024, 16'd2, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd16581375, 16'd3, cbqv_pkg::MAP_LATTICE);
                offer_item(24'd243, 16'd5, cbqv_pkg::MAP_LATTICE);
                offer_item(24'h555555, 16'hAAAA, cbqv_pkg::MAP_LATTICE);
                offer_item(24'h800000, 16'h8000, cbqv_pkg::MAP_LATTICE);
            end

            repeat (317)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    kind = cbqv_pkg::MAP_LATTICE;
                else if (pick < 80)
                    kind = cbqv_pkg::MAP_LIST;
                else if (pick < 90)
                    kind = cbqv_pkg::MAP_NONE;
                else
                    kind = MAP_UNUSED;

                pick = $urandom_range(99);
                if (pick < 40)
                    dim = cbqv_pkg::DIM_BITS'($urandom_range(1, 4));
                else if (pick < 60)
                    dim = cbqv_pkg::DIM_BITS'($urandom_range(5, 30));
                else if (pick < 95)
                    dim = cbqv_pkg::DIM_BITS'($urandom);
                else
                    dim = '0;

                pick = $urandom_range(99);
                if (pick < 35)
                    entries = cbqv_pkg::ENTRY_BITS'($urandom);
                else if (pick < 55)
                    entries = cbqv_pkg::ENTRY_BITS'($urandom_range(0, 300));
                else
                begin
                    // entry count on or next to an exact power with the dimension as exponent
                    if (dim == 0 || dim > 24)
                        dim = cbqv_pkg::DIM_BITS'($urandom_range(1, 8));
                    top = book.lattice_root('1, dim);
                    root = $urandom_range(1, 32'(top));
                    pw = 1;
                    repeat (dim)
                        pw = pw * root;
                    entries = cbqv_pkg::ENTRY_BITS'(pw + $urandom_range(0, 2) - 1);
                end

                offer_item(entries, dim, kind);
            end
        end

        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        // let a stray result show up
        repeat (700) @(posedge clk);
        if (book.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #12000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
